/* design/mdb_master_transaction_macros.svh */
// ----------------------------------------------------------------------------
// mdb_master_transaction_macros
// Assertion helpers used by the mdb_back module of the bus master. Both macros
// expect clk and rst_n to be visible where they are used.
// ----------------------------------------------------------------------------
`ifndef MDB_MASTER_TRANSACTION_MACROS_SVH
`define MDB_MASTER_TRANSACTION_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MDB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mdb assertion failed in the same cycle");

// Checks that the consequent holds in the cycle after the antecedent.
`define MDB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mdb assertion failed in the following cycle");

`endif

/* design/mdb_pkg.sv */
// ----------------------------------------------------------------------------
// mdb_pkg
// Types and constants shared by the multi-drop bus master modules.
// ----------------------------------------------------------------------------
package mdb_pkg;

  localparam logic [2:0] CMD_LOAD_PARAM = 3'd0;
  localparam logic [2:0] CMD_SEND_FRAME = 3'd1;
  localparam logic [2:0] CMD_RX_WORD    = 3'd2;
  localparam logic [2:0] CMD_TICK       = 3'd3;
  localparam logic [2:0] CMD_SEND_ACK   = 3'd4;

  localparam logic [1:0] KIND_TX_WORD    = 2'd0;
  localparam logic [1:0] KIND_REPLY_BYTE = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT    = 2'd2;

  localparam logic [8:0] MODE_BIT  = 9'h100;
  localparam logic [7:0] ACK_CODE  = 8'h00;
  localparam logic [7:0] NAK_CODE  = 8'hFF;
  localparam logic [15:0] TICK_MAX = 16'hFFFF;
  localparam logic [15:0] TIMEOUT_RESET = 16'd5;

  localparam int JOB_IDX_W   = 6;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] param_byte;
    logic [7:0] device_address;
    logic [7:0] command_code;
    logic [8:0] received_word;
    logic       ack_is_nak;
  } in_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [8:0] transmit_word;
    logic [7:0] reply_byte;
    logic [5:0] reply_count;
    logic       last;
    logic       overflow;
  } out_t;

  typedef enum logic [1:0] {
    JOB_LOAD   = 2'd0,
    JOB_FRAME  = 2'd1,
    JOB_RESULT = 2'd2
  } job_op_t;

  typedef struct packed {
    job_op_t              op;
    logic [7:0]           data;
    logic [JOB_IDX_W-1:0] idx;
    out_t                 res;
  } job_t;

endpackage

/* design/mdb_front.sv */
// ----------------------------------------------------------------------------
// mdb_front
// Accepts transactions, tracks the reply state and turns those that need an action into jobs.
// ----------------------------------------------------------------------------
module mdb_front #(
  parameter int FRAME_WORDS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  input  mdb_pkg::in_t   in_data,
  input  logic           cfg_valid,
  input  logic [15:0]    cfg_data,
  input  logic           q_full,
  output logic           q_push,
  output mdb_pkg::job_t  q_job
);

  localparam int MAX_PARAMS  = FRAME_WORDS - 2;
  localparam int CW          = $clog2(MAX_PARAMS + 1);
  localparam int REPLY_LIMIT = (FRAME_WORDS > 63) ? 63 : FRAME_WORDS;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PARAMS);
  localparam logic [5:0]    REPLY_MAX = 6'(REPLY_LIMIT);

  logic [15:0]   timeout_r;
  logic [CW-1:0] pcount_r, pcount_nxt;
  logic          await_r, await_nxt;
  logic [15:0]   idle_r, idle_nxt, idle_inc;
  logic [5:0]    rindex_r, rindex_nxt;
  logic [15:0]   limit;
  logic          accept;
  logic          rx_end;

  assign accept = in_push && !q_full;
  assign limit  = (timeout_r == 16'd0) ? 16'd1 : timeout_r;
  assign rx_end = in_data.received_word[8];
  assign idle_inc = (idle_r < mdb_pkg::TICK_MAX) ? idle_r + 16'd1 : idle_r;

  always_comb begin
    pcount_nxt = pcount_r;
    await_nxt  = await_r;
    idle_nxt   = idle_r;
    rindex_nxt = rindex_r;
    q_push     = 1'b0;
    q_job      = '0;
    q_job.op   = mdb_pkg::JOB_RESULT;
    if (accept) begin
      unique case (in_data.command)
        mdb_pkg::CMD_LOAD_PARAM: begin
          if (pcount_r < MAX_CNT) begin
            q_push     = 1'b1;
            q_job.op   = mdb_pkg::JOB_LOAD;
            q_job.data = in_data.param_byte;
            q_job.idx  = mdb_pkg::JOB_IDX_W'(pcount_r);
            pcount_nxt = pcount_r + CW'(1);
          end
        end
        mdb_pkg::CMD_SEND_FRAME: begin
          q_push     = 1'b1;
          q_job.op   = mdb_pkg::JOB_FRAME;
          q_job.data = in_data.device_address + in_data.command_code;
          q_job.idx  = mdb_pkg::JOB_IDX_W'(pcount_r);
          pcount_nxt = '0;
          await_nxt  = 1'b1;
          idle_nxt   = '0;
          rindex_nxt = '0;
        end
        mdb_pkg::CMD_RX_WORD: begin
          if (await_r) begin
            q_push                = 1'b1;
            q_job.res.result_kind = mdb_pkg::KIND_REPLY_BYTE;
            q_job.res.last        = rx_end;
            idle_nxt              = '0;
            if (rindex_r < REPLY_MAX) begin
              rindex_nxt            = rindex_r + 6'd1;
              q_job.res.reply_byte  = in_data.received_word[7:0];
              q_job.res.reply_count = rindex_r + 6'd1;
            end else begin
              q_job.res.reply_count = REPLY_MAX;
              q_job.res.overflow    = 1'b1;
            end
            if (rx_end) begin
              await_nxt = 1'b0;
            end
          end
        end
        mdb_pkg::CMD_TICK: begin
          if (await_r) begin
            idle_nxt = idle_inc;
            if (idle_inc >= limit) begin
              q_push                = 1'b1;
              q_job.res.result_kind = mdb_pkg::KIND_TIMEOUT;
              q_job.res.reply_byte  = mdb_pkg::NAK_CODE;
              q_job.res.last        = 1'b1;
              await_nxt             = 1'b0;
              idle_nxt              = '0;
              rindex_nxt            = '0;
            end
          end
        end
        mdb_pkg::CMD_SEND_ACK: begin
          q_push                  = 1'b1;
          q_job.res.result_kind   = mdb_pkg::KIND_TX_WORD;
          q_job.res.transmit_word = {1'b0, in_data.ack_is_nak ? mdb_pkg::NAK_CODE
                                                              : mdb_pkg::ACK_CODE};
          q_job.res.last          = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= mdb_pkg::TIMEOUT_RESET;
      pcount_r  <= '0;
      await_r   <= 1'b0;
      idle_r    <= '0;
      rindex_r  <= '0;
    end else begin
      if (cfg_valid) begin
        timeout_r <= cfg_data;
      end
      pcount_r <= pcount_nxt;
      await_r  <= await_nxt;
      idle_r   <= idle_nxt;
      rindex_r <= rindex_nxt;
    end
  end

endmodule

/* design/mdb_queue.sv */
// ----------------------------------------------------------------------------
// mdb_queue
// Short first-word-fall-through queue of jobs between front and back.
// ----------------------------------------------------------------------------
module mdb_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mdb_pkg::job_t  push_job,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output mdb_pkg::job_t  head_job
);

  localparam int PW = $clog2(mdb_pkg::QUEUE_DEPTH);
  localparam int NW = $clog2(mdb_pkg::QUEUE_DEPTH + 1);

  mdb_pkg::job_t entry_r [mdb_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] count_r;
  logic          do_push, do_pop;

  assign full     = (count_r == NW'(mdb_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + NW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - NW'(1);
      end
    end
  end

endmodule

/* design/mdb_back.sv */
// ----------------------------------------------------------------------------
// mdb_back
// Carries out jobs: holds the parameter store, emits frames and results.
// ----------------------------------------------------------------------------
`include "mdb_master_transaction_macros.svh"

module mdb_back #(
  parameter int FRAME_WORDS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  mdb_pkg::job_t  q_job,
  output logic           q_pop,
  output logic           out_empty,
  input  logic           out_pop,
  output mdb_pkg::out_t  out_data
);

  localparam int MAX_PARAMS = FRAME_WORDS - 2;
  localparam int AW = $clog2(MAX_PARAMS);
  localparam int CW = $clog2(MAX_PARAMS + 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ADDR  = 5'b00010,
    ST_FETCH = 5'b00100,
    ST_EMIT  = 5'b01000,
    ST_SUM   = 5'b10000
  } state_t;

  logic [7:0]    store_mem [MAX_PARAMS];
  logic [7:0]    rd_data_r;
  state_t        state_r, state_nxt;
  logic [7:0]    low_r, low_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          out_valid_r;
  mdb_pkg::out_t out_r;
  logic          slot_free;
  logic          emit;
  mdb_pkg::out_t emit_res;
  logic          mem_we;

  assign slot_free = !out_valid_r || out_pop;
  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r;
    low_nxt   = low_r;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    emit      = 1'b0;
    emit_res  = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          unique case (q_job.op)
            mdb_pkg::JOB_LOAD: begin
              q_pop  = 1'b1;
              mem_we = 1'b1;
            end
            mdb_pkg::JOB_FRAME: begin
              q_pop     = 1'b1;
              low_nxt   = q_job.data;
              sum_nxt   = q_job.data;
              cnt_nxt   = CW'(q_job.idx);
              state_nxt = ST_ADDR;
            end
            mdb_pkg::JOB_RESULT: begin
              if (slot_free) begin
                q_pop    = 1'b1;
                emit     = 1'b1;
                emit_res = q_job.res;
              end
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      ST_ADDR: begin
        if (slot_free) begin
          emit                   = 1'b1;
          emit_res.transmit_word = mdb_pkg::MODE_BIT | {1'b0, low_r};
          idx_nxt                = '0;
          state_nxt              = (cnt_r == '0) ? ST_SUM : ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          emit                   = 1'b1;
          emit_res.transmit_word = {1'b0, rd_data_r};
          sum_nxt                = sum_r + rd_data_r;
          idx_nxt                = idx_r + CW'(1);
          state_nxt              = (idx_r + CW'(1) == cnt_r) ? ST_SUM : ST_FETCH;
        end
      end
      ST_SUM: begin
        if (slot_free) begin
          emit                   = 1'b1;
          emit_res.transmit_word = {1'b0, sum_r};
          emit_res.last          = 1'b1;
          state_nxt              = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[q_job.idx[AW-1:0]] <= q_job.data;
    end
    rd_data_r <= store_mem[idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    low_r <= low_nxt;
    sum_r <= sum_nxt;
    cnt_r <= cnt_nxt;
    idx_r <= idx_nxt;
    if (emit) begin
      out_r <= emit_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `MDB_ASSERT_NEXT(a_out_hold, out_valid_r && !out_pop, out_valid_r && $stable(out_r))
  `MDB_ASSERT_NEXT(a_sum_last, state_r == ST_SUM && slot_free, out_valid_r && out_r.last)
  `MDB_ASSERT_SAME(a_fetch_range, state_r == ST_FETCH || state_r == ST_EMIT, idx_r < cnt_r)

endmodule

/* design/mdb_master_transaction.sv */
// ----------------------------------------------------------------------------
// mdb_master_transaction
// With the back part idle, an accepted result goes through the job queue and the output register.
// Throughput: one per cycle until the job queue fills; a frame sends address, parameters, then sum.
// Reset clears the queue, output valid flag, reply state and parameter count; timeout is 5.
// ----------------------------------------------------------------------------
module mdb_master_transaction #(
  parameter int FRAME_WORDS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  input  mdb_pkg::in_t  in_data,
  output logic          in_full,
  output logic          out_empty,
  input  logic          out_pop,
  output mdb_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [15:0]   cfg_data
);

  logic          q_push, q_full, q_pop, q_empty;
  mdb_pkg::job_t push_job, head_job;

  assign in_full   = q_full;
  assign cfg_ready = 1'b1;

  mdb_front #(
    .FRAME_WORDS(FRAME_WORDS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  mdb_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_job(push_job),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .head_job(head_job)
  );

  mdb_back #(
    .FRAME_WORDS(FRAME_WORDS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_job    (head_job),
    .q_pop    (q_pop),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

endmodule
